FILE: hdl/fte_pkg.sv
// ----------------------------------------------------------------------------
// fte_pkg
// Shared types, codes and constants of the allocation table block.
// ----------------------------------------------------------------------------
package fte_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 4096;
  localparam int INDEX_SPAN          = 4096;
  localparam int INDEX_W             = 12;
  localparam int COUNT_W             = 13;
  localparam int LINK_W              = 28;
  localparam int WORD_W              = 32;
  localparam int QUEUE_DEPTH         = 2;

  localparam logic [WORD_W-1:0] LINK_MASK = 32'h0FFF_FFFF;
  localparam logic [WORD_W-1:0] RSVD_MASK = 32'hF000_0000;

  localparam logic [COUNT_W-1:0] ENTRIES_RESET = 13'd4096;
  localparam logic [LINK_W-1:0]  EOC_RESET     = 28'hFFF_FFFF;

  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_ALLOC  = 3'd2;
  localparam logic [2:0] OP_LOAD   = 3'd3;
  localparam logic [2:0] OP_SETCNT = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic REG_TABLE_ENTRIES = 1'b0;
  localparam logic REG_END_OF_CHAIN  = 1'b1;

  typedef enum logic [2:0] {
    CMD_READ,
    CMD_WRITE,
    CMD_ALLOC,
    CMD_LOAD,
    CMD_SETCNT,
    CMD_RANGE,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [INDEX_W-1:0] index;
    logic [WORD_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [LINK_W-1:0]  entry_value;
    logic [INDEX_W-1:0] allocated_index;
    logic [WORD_W-1:0]  used_count;
  } rsp_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [INDEX_W-1:0] index;
    logic [WORD_W-1:0]  value;
    logic [COUNT_W-1:0] limit;
  } cmd_t;

endpackage

FILE: hdl/fte_front.sv
// ----------------------------------------------------------------------------
// fte_front
// Accepts requests, checks the index against the live entry count and
// turns each request into a command for the back end.
// ----------------------------------------------------------------------------
module fte_front #(
  parameter int MEM_DEPTH = fte_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                          req_valid,
  output logic                          req_ready,
  input  fte_pkg::req_t                 req,
  input  logic [fte_pkg::COUNT_W-1:0]   table_entries,
  input  logic                          q_full,
  output logic                          q_push,
  output fte_pkg::cmd_t                 q_cmd
);
  import fte_pkg::*;

  localparam logic [COUNT_W-1:0] DEPTH_CAP = COUNT_W'(MEM_DEPTH);

  logic [COUNT_W-1:0] live;
  logic               out_of_range;

  assign live         = (table_entries < DEPTH_CAP) ? table_entries : DEPTH_CAP;
  assign out_of_range = {1'b0, req.index} >= live;
  assign req_ready    = !q_full;
  assign q_push       = req_valid && !q_full;

  always_comb begin
    q_cmd.index = req.index;
    q_cmd.value = req.value;
    q_cmd.limit = live;
    unique case (req.operation)
      OP_READ:   q_cmd.kind = out_of_range ? CMD_RANGE : CMD_READ;
      OP_WRITE:  q_cmd.kind = out_of_range ? CMD_RANGE : CMD_WRITE;
      OP_LOAD:   q_cmd.kind = out_of_range ? CMD_RANGE : CMD_LOAD;
      OP_ALLOC:  q_cmd.kind = CMD_ALLOC;
      OP_SETCNT: q_cmd.kind = CMD_SETCNT;
      default:   q_cmd.kind = CMD_NOP;
    endcase
  end

endmodule

FILE: hdl/fte_queue.sv
// ----------------------------------------------------------------------------
// fte_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module fte_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fte_pkg::cmd_t push_cmd,
  input  logic          pop,
  output fte_pkg::cmd_t pop_cmd,
  output logic          full,
  output logic          empty
);
  import fte_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full    = fill == CNT_W'(QUEUE_DEPTH);
  assign empty   = fill == '0;
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

FILE: hdl/fte_back.sv
// ----------------------------------------------------------------------------
// fte_back
// Executes commands against the entry memory and the used counter, and
// holds each result in an output register.
// ----------------------------------------------------------------------------
module fte_back #(
  parameter int MEM_DEPTH = fte_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [fte_pkg::LINK_W-1:0]   end_of_chain_value,
  input  logic                         q_empty,
  input  fte_pkg::cmd_t                q_cmd,
  output logic                         q_pop,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output fte_pkg::rsp_t                rsp
);
  import fte_pkg::*;

  localparam int ADDR_W = $clog2(MEM_DEPTH);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_RDWAIT = 2'd1;
  localparam logic [1:0] S_WRWAIT = 2'd2;
  localparam logic [1:0] S_SCAN   = 2'd3;

  logic [WORD_W-1:0]  mem [MEM_DEPTH];
  logic [WORD_W-1:0]  mem_q;

  logic [1:0]         state;
  logic [1:0]         state_next;
  cmd_t               cur;
  logic [WORD_W-1:0]  used;
  logic [WORD_W-1:0]  used_next;
  logic [INDEX_W-1:0] chk_idx;
  logic [INDEX_W-1:0] chk_idx_next;

  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic               fin;
  rsp_t               rsp_next;

  logic [LINK_W-1:0]  wr_link;
  logic [COUNT_W-1:0] chk_succ;

  assign q_pop    = (state == S_IDLE) && !q_empty && (!rsp_valid || rsp_ready);
  assign wr_link  = cur.value[LINK_W-1:0];
  assign chk_succ = {1'b0, chk_idx} + COUNT_W'(1);

  always_comb begin
    state_next   = state;
    used_next    = used;
    chk_idx_next = chk_idx;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;
    fin          = 1'b0;
    rsp_next     = '0;

    unique case (state)
      S_IDLE: begin
        if (q_pop) begin
          unique case (q_cmd.kind)
            CMD_READ: begin
              rd_en      = 1'b1;
              rd_addr    = q_cmd.index[ADDR_W-1:0];
              state_next = S_RDWAIT;
            end
            CMD_WRITE: begin
              rd_en      = 1'b1;
              rd_addr    = q_cmd.index[ADDR_W-1:0];
              state_next = S_WRWAIT;
            end
            CMD_ALLOC: begin
              if (q_cmd.limit > COUNT_W'(1)) begin
                rd_en        = 1'b1;
                rd_addr      = ADDR_W'(1);
                chk_idx_next = INDEX_W'(1);
                state_next   = S_SCAN;
              end else begin
                fin             = 1'b1;
                rsp_next.status = ST_FULL;
              end
            end
            CMD_LOAD: begin
              wr_en   = 1'b1;
              wr_addr = q_cmd.index[ADDR_W-1:0];
              wr_data = q_cmd.value;
              fin     = 1'b1;
            end
            CMD_SETCNT: begin
              used_next = q_cmd.value;
              fin       = 1'b1;
            end
            CMD_RANGE: begin
              fin             = 1'b1;
              rsp_next.status = ST_RANGE;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        fin                  = 1'b1;
        rsp_next.entry_value = mem_q[LINK_W-1:0];
        state_next           = S_IDLE;
      end
      S_WRWAIT: begin
        wr_en   = 1'b1;
        wr_addr = cur.index[ADDR_W-1:0];
        wr_data = (mem_q & RSVD_MASK) | {4'b0, wr_link};
        if (wr_link == end_of_chain_value) begin
          used_next = used + WORD_W'(1);
        end else if (wr_link == '0) begin
          used_next = used - WORD_W'(1);
        end
        fin        = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (mem_q[LINK_W-1:0] == '0) begin
          wr_en                    = 1'b1;
          wr_addr                  = chk_idx[ADDR_W-1:0];
          wr_data                  = (mem_q & RSVD_MASK) | {4'b0, end_of_chain_value};
          used_next                = used + WORD_W'(1);
          fin                      = 1'b1;
          rsp_next.allocated_index = chk_idx;
          state_next               = S_IDLE;
        end else if (chk_succ >= cur.limit) begin
          fin             = 1'b1;
          rsp_next.status = ST_FULL;
          state_next      = S_IDLE;
        end else begin
          rd_en        = 1'b1;
          rd_addr      = chk_succ[ADDR_W-1:0];
          chk_idx_next = chk_succ[INDEX_W-1:0];
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    rsp_next.used_count = used_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
    chk_idx <= chk_idx_next;
    if (fin) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      if (fin) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/fat_table_entry_allocator.sv
// ----------------------------------------------------------------------------
// fat_table_entry_allocator
// Allocation table of 32-bit entries with read, write, allocate, load and
// used-counter preset operations.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_ready, one result per request leaves on
// rsp_valid/rsp_ready in request order. Configuration writes (cfg_index 0:
// entry count, 1: end-of-chain marker) are always taken and must be issued
// while no request is outstanding.
// A front stage checks the index against the live entry count and queues a
// command; the back end runs it against a single-port entry memory whose
// read data is registered.
// Load, set-count and rejected requests finish as they leave the queue;
// read and write first read the entry, and write then updates it;
// allocate scans from entry 1 until a free entry is found or the table
// runs out, the scan visiting one entry per cycle.
// The back end runs one command at a time and takes the next once its result
// register is free: one per cycle for load, set-count and rejected requests,
// while read, write and allocate take no new command until they finish.
// The queue keeps accepting while a result waits until its two slots fill.
// Reset clears the used counter, restores the configuration defaults and
// empties the queue and the output register; the entry memory is not
// cleared and must be written before it is read. A stalled receiver holds
// the result in place and, once the queue fills, holds off new requests.
// ----------------------------------------------------------------------------
module fat_table_entry_allocator #(
  parameter int TABLE_DEPTH = fte_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  fte_pkg::req_t               req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output fte_pkg::rsp_t               rsp,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [fte_pkg::WORD_W-1:0]  cfg_data
);
  import fte_pkg::*;

  localparam int MEM_DEPTH = (TABLE_DEPTH < INDEX_SPAN) ? TABLE_DEPTH : INDEX_SPAN;

  logic [COUNT_W-1:0] table_entries;
  logic [LINK_W-1:0]  end_of_chain_value;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  cmd_t               push_cmd;
  cmd_t               pop_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_entries      <= ENTRIES_RESET;
      end_of_chain_value <= EOC_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TABLE_ENTRIES: table_entries      <= cfg_data[COUNT_W-1:0];
        REG_END_OF_CHAIN:  end_of_chain_value <= cfg_data[LINK_W-1:0];
        default: ;
      endcase
    end
  end

  fte_front #(.MEM_DEPTH(MEM_DEPTH)) u_front (
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .table_entries (table_entries),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  fte_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  fte_back #(.MEM_DEPTH(MEM_DEPTH)) u_back (
    .clk                (clk),
    .rst                (rst),
    .end_of_chain_value (end_of_chain_value),
    .q_empty            (q_empty),
    .q_cmd              (pop_cmd),
    .q_pop              (q_pop),
    .rsp_valid          (rsp_valid),
    .rsp_ready          (rsp_ready),
    .rsp                (rsp)
  );

endmodule

FILE: hdl/fte_checker.sv
// ----------------------------------------------------------------------------
// fte_checker
// Port-level checks of the allocation table block, bound to the top level.
// ----------------------------------------------------------------------------
module fte_checker (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input fte_pkg::rsp_t rsp
);
  import fte_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_RANGE ||
                   rsp.status == ST_FULL))
    else $error("bad status code");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |->
      rsp.entry_value == '0 && rsp.allocated_index == '0)
    else $error("failed request carries data");

endmodule

bind fat_table_entry_allocator fte_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

FILE: tb/fat_table_entry_allocator_tb.sv
// ----------------------------------------------------------------------------
// fat_table_entry_allocator_tb
// Self-checking bench for the allocation table block. A short scripted
// sequence covers reset values, index extremes, counter wrap, range and
// full-table errors, spare opcodes and a zero end-of-chain marker. Random
// phases follow, each with its own configuration, under varied traffic.
// Results are checked against script values or a behavioral table mirror.
// ----------------------------------------------------------------------------
module fat_table_entry_allocator_tb;
  import fte_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int          HOT_SPAN      = 64;
  localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;

  typedef struct {
    bit                is_cfg;
    logic [WORD_W-1:0] entries_word;
    logic [WORD_W-1:0] eoc_word;
    req_t              r;
    bit                typed;
    rsp_t              want;
  } step_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  req_t              req       = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  rsp_t              rsp;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = REG_TABLE_ENTRIES;
  logic [WORD_W-1:0] cfg_data  = '0;

  logic [WORD_W-1:0]  mirror_word [INDEX_SPAN];
  bit                 mirror_loaded [INDEX_SPAN];
  logic [WORD_W-1:0]  mirror_used    = '0;
  logic [COUNT_W-1:0] mirror_entries = ENTRIES_RESET;
  logic [LINK_W-1:0]  mirror_eoc     = EOC_RESET;
  rsp_t               outcome_q [$];
  step_t              script [$];

  int          send_idle    = 0;
  int          recv_idle    = 0;
  int          hold_asks    = 0;
  int          holds_done   = 0;
  int          hold_left    = 0;
  int          items_sent   = 0;
  int          results_seen = 0;
  int          errors       = 0;
  int          alloc_hits   = 0;
  int          alloc_full   = 0;
  int          range_hits   = 0;
  int unsigned cycles       = 0;
  rsp_t        want;

  fat_table_entry_allocator i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int live_entries();
    int n;
    n = int'(mirror_entries);
    if (n > TABLE_DEPTH_DEFAULT) n = TABLE_DEPTH_DEFAULT;
    if (n > INDEX_SPAN) n = INDEX_SPAN;
    return n;
  endfunction

  function automatic void store_link(int idx, logic [LINK_W-1:0] link);
    mirror_word[idx] = {mirror_word[idx][WORD_W-1:LINK_W], link};
    if (link == mirror_eoc) begin
      mirror_used = mirror_used + 1;
    end else if (link == '0) begin
      mirror_used = mirror_used - 1;
    end
  endfunction

  function automatic rsp_t table_outcome(req_t r);
    rsp_t o;
    int   n;
    int   i;
    bit   found;
    o = '0;
    n = live_entries();
    found = 1'b0;
    case (r.operation)
      OP_READ, OP_WRITE, OP_LOAD: begin
        if (int'(r.index) >= n) begin
          o.status = ST_RANGE;
          range_hits++;
        end else if (r.operation == OP_READ) begin
          o.entry_value = mirror_word[r.index][LINK_W-1:0];
        end else begin
          if (r.operation == OP_WRITE) store_link(int'(r.index), r.value[LINK_W-1:0]);
          else mirror_word[r.index] = r.value;
          mirror_loaded[r.index] = 1'b1;
        end
      end
      OP_ALLOC: begin
        o.status = ST_FULL;
        for (i = 1; i < n && !found; i++) begin
          if (mirror_word[i][LINK_W-1:0] == '0) begin
            store_link(i, mirror_eoc);
            o.allocated_index = i[INDEX_W-1:0];
            o.status = ST_OK;
            found = 1'b1;
          end
        end
        if (found) alloc_hits++;
        else alloc_full++;
      end
      OP_SETCNT: mirror_used = r.value;
      default: ;
    endcase
    o.used_count = mirror_used;
    return o;
  endfunction

  // first never-written entry that an allocate scan would touch, or -1
  function automatic int scan_hazard();
    int n;
    int i;
    n = live_entries();
    i = 1;
    while (i < n && mirror_loaded[i] && mirror_word[i][LINK_W-1:0] != '0) i++;
    return (i < n && !mirror_loaded[i]) ? i : -1;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word(logic [2:0] op);
    int         r;
    logic [3:0] top;
    r = $urandom_range(0, 9);
    top = 4'($urandom);
    case (op)
      OP_WRITE: begin
        if (r < 3) return {top, mirror_eoc};
        if (r < 6) return {top, {LINK_W{1'b0}}};
      end
      OP_LOAD: begin
        if (r < 4) return {top, {LINK_W{1'b0}}};
        if (r < 6) return {top, mirror_eoc};
      end
      OP_SETCNT: begin
        if (r < 3) return 32'hFFFF_FFFF - $urandom_range(0, 3);
        if (r < 5) return $urandom_range(0, 3);
      end
      default: ;
    endcase
    return $urandom;
  endfunction

  function automatic req_t make_request();
    req_t r;
    int   n;
    int   pick;
    int   gap;
    n = live_entries();
    pick = $urandom_range(0, 99);
    if (pick < 25) r.operation = OP_READ;
    else if (pick < 50) r.operation = OP_WRITE;
    else if (pick < 65) r.operation = OP_ALLOC;
    else if (pick < 85) r.operation = OP_LOAD;
    else if (pick < 92) r.operation = OP_SETCNT;
    else r.operation = 3'(OP_SPARE_FIRST + $urandom_range(0, OP_SPARE_LAST - OP_SPARE_FIRST));
    pick = $urandom_range(0, 99);
    if (n > 0 && pick < 60)
      r.index = INDEX_W'($urandom_range(0, (n < HOT_SPAN ? n : HOT_SPAN) - 1));
    else if (n > 0 && pick < 85) r.index = INDEX_W'($urandom_range(0, n - 1));
    else r.index = INDEX_W'($urandom);
    r.value = pick_word(r.operation);
    if ((r.operation == OP_READ || r.operation == OP_WRITE) && int'(r.index) < n &&
        !mirror_loaded[r.index]) begin
      r.operation = OP_LOAD;
      r.value = pick_word(OP_LOAD);
    end
    if (r.operation == OP_ALLOC) begin
      gap = scan_hazard();
      if (gap >= 0) begin
        r.operation = OP_LOAD;
        r.index = gap[INDEX_W-1:0];
        r.value = pick_word(OP_LOAD);
      end
    end
    return r;
  endfunction

  function automatic void plan_req(logic [2:0] op, logic [INDEX_W-1:0] idx,
                                   logic [WORD_W-1:0] val, bit typed = 1'b0,
                                   logic [1:0] st = ST_OK, logic [LINK_W-1:0] ev = '0,
                                   logic [INDEX_W-1:0] ai = '0, logic [WORD_W-1:0] uc = '0);
    step_t s;
    s = '{default: '0};
    s.r.operation = op;
    s.r.index = idx;
    s.r.value = val;
    s.typed = typed;
    s.want = {st, ev, ai, uc};
    script.push_back(s);
  endfunction

  function automatic void plan_cfg(logic [WORD_W-1:0] entries_word, logic [WORD_W-1:0] eoc_word);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.entries_word = entries_word;
    s.eoc_word = eoc_word;
    script.push_back(s);
  endfunction

  function automatic void check_field(string name, logic [WORD_W-1:0] exp_v,
                                      logic [WORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endfunction

  task automatic send(req_t r, bit typed, rsp_t typed_want);
    rsp_t p;
    while ($urandom_range(0, 99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    p = table_outcome(r);
    outcome_q.push_back(typed ? typed_want : p);
    items_sent++;
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (outcome_q.size() != 0);
  endtask

  task automatic configure(logic [WORD_W-1:0] entries_word, logic [WORD_W-1:0] eoc_word);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= REG_TABLE_ENTRIES;
    cfg_data <= entries_word;
    do @(posedge clk); while (!cfg_ready);
    mirror_entries = entries_word[COUNT_W-1:0];
    cfg_index <= REG_END_OF_CHAIN;
    cfg_data <= eoc_word;
    do @(posedge clk); while (!cfg_ready);
    mirror_eoc = eoc_word[LINK_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int count, logic [COUNT_W-1:0] entries, logic [LINK_W-1:0] eoc,
                           int hold_at, int pause_at);
    logic [WORD_W-1:0] ew;
    logic [WORD_W-1:0] cw;
    int                k;
    ew = $urandom;
    ew[COUNT_W-1:0] = entries;
    cw = $urandom;
    cw[LINK_W-1:0] = eoc;
    configure(ew, cw);
    for (k = 0; k < count; k++) begin
      if (k == hold_at) hold_asks <= hold_asks + 1;
      if (k == pause_at) drain_results();
      send(make_request(), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (hold_asks != holds_done) begin
      holds_done = hold_asks;
      hold_left = HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (outcome_q.size() == 0) begin
        errors++;
        $display("%0t: result with none pending, expected nothing, actual %h", $time, rsp);
      end else begin
        want = outcome_q.pop_front();
        check_field("status", WORD_W'(want.status), WORD_W'(rsp.status));
        check_field("entry_value", WORD_W'(want.entry_value), WORD_W'(rsp.entry_value));
        check_field("allocated_index", WORD_W'(want.allocated_index),
                    WORD_W'(rsp.allocated_index));
        check_field("used_count", want.used_count, rsp.used_count);
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, outcome_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int i;
    for (i = 0; i < INDEX_SPAN; i++) begin
      mirror_word[i] = '0;
      mirror_loaded[i] = 1'b0;
    end

    plan_req(OP_LOAD,   12'd0,    32'hFFFF_FFFF, 1, ST_OK, 28'h0, 12'd0, 32'd0);
    plan_req(OP_READ,   12'd0,    32'h0,         1, ST_OK, 28'hFFF_FFFF, 12'd0, 32'd0);
    plan_req(OP_LOAD,   12'd4095, 32'h0,         1, ST_OK, 28'h0, 12'd0, 32'd0);
    plan_req(OP_WRITE,  12'd4095, 32'hFFFF_FFFF, 1, ST_OK, 28'h0, 12'd0, 32'd1);
    plan_req(OP_READ,   12'd4095, 32'h0,         1, ST_OK, 28'hFFF_FFFF, 12'd0, 32'd1);
    plan_req(OP_SETCNT, 12'd0,    32'hFFFF_FFFF, 1, ST_OK, 28'h0, 12'd0, 32'hFFFF_FFFF);
    plan_req(OP_WRITE,  12'd0,    32'h0FFF_FFFF, 1, ST_OK, 28'h0, 12'd0, 32'd0);
    plan_req(OP_WRITE,  12'd4095, 32'hF000_0000, 1, ST_OK, 28'h0, 12'd0, 32'hFFFF_FFFF);
    plan_req(OP_SPARE_FIRST, 12'hABC, 32'h1234_5678, 1, ST_OK, 28'h0, 12'd0, 32'hFFFF_FFFF);
    plan_req(OP_SPARE_LAST,  12'hFFF, 32'hFFFF_FFFF, 1, ST_OK, 28'h0, 12'd0, 32'hFFFF_FFFF);
    plan_req(OP_LOAD,   12'd1,    32'hA000_0000, 1, ST_OK, 28'h0, 12'd0, 32'hFFFF_FFFF);
    plan_req(OP_ALLOC,  12'd0,    32'h0,         1, ST_OK, 28'h0, 12'd1, 32'd0);
    plan_req(OP_READ,   12'd1,    32'h0,         1, ST_OK, 28'hFFF_FFFF, 12'd0, 32'd0);
    plan_cfg(32'd2, {4'h0, EOC_RESET});
    plan_req(OP_ALLOC,  12'd0,    32'h0,         1, ST_FULL, 28'h0, 12'd0, 32'd0);
    plan_req(OP_READ,   12'd2,    32'h0,         1, ST_RANGE, 28'h0, 12'd0, 32'd0);
    plan_req(OP_LOAD,   12'd4095, 32'h5555_AAAA, 1, ST_RANGE, 28'h0, 12'd0, 32'd0);
    plan_cfg(32'd0, {4'h0, EOC_RESET});
    plan_req(OP_READ,   12'd0,    32'h0,         1, ST_RANGE, 28'h0, 12'd0, 32'd0);
    plan_req(OP_ALLOC,  12'd0,    32'h0,         1, ST_FULL, 28'h0, 12'd0, 32'd0);
    plan_cfg(32'd4, 32'd0);
    plan_req(OP_LOAD,   12'd2,    32'h5000_0000, 1, ST_OK, 28'h0, 12'd0, 32'd0);
    plan_req(OP_WRITE,  12'd2,    32'h3000_0000, 1, ST_OK, 28'h0, 12'd0, 32'd1);
    plan_req(OP_ALLOC,  12'd0,    32'h0);
    plan_req(3'd6,      12'd3,    32'hDEAD_BEEF);
    plan_req(OP_WRITE,  12'd2,    32'h0FFF_FFFF);
    plan_cfg(32'd1, 32'd0);
    plan_req(OP_WRITE,  12'd1,    32'h0000_0001, 1, ST_RANGE, 28'h0, 12'd0, 32'd2);
    plan_req(OP_READ,   12'd0,    32'h0);

    send_idle = 14;
    recv_idle <= 81;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_cfg) configure(script[i].entries_word, script[i].eoc_word);
      else send(script[i].r, script[i].typed, script[i].want);
    end

    run_phase(200, 13'd16, LINK_W'($urandom), -1, -1);
    run_phase(150, ENTRIES_RESET, EOC_RESET, -1, 60);
    send_idle = 81;
    recv_idle <= 14;
    run_phase(60, 13'd1, '0, -1, -1);
    run_phase(200, COUNT_W'($urandom_range(2, 63)), LINK_W'($urandom), -1, 100);
    send_idle = 0;
    recv_idle <= 0;
    run_phase(150, 13'h1FFF, LINK_W'($urandom), -1, -1);
    run_phase(40, 13'd0, LINK_W'($urandom), -1, -1);
    run_phase(300, 13'd64, LINK_W'($urandom), 20, -1);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d requests sent, %0d results checked, %0d mismatches",
             items_sent, results_seen, errors);
    $display("allocate claimed %0d entries and hit a full table %0d times; %0d range rejects",
             alloc_hits, alloc_full, range_hits);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/fte_pkg.sv
hdl/fte_front.sv
hdl/fte_queue.sv
hdl/fte_back.sv
hdl/fat_table_entry_allocator.sv
hdl/fte_checker.sv
tb/fat_table_entry_allocator_tb.sv
